>>> rtl/core/thf_pkg.sv
package thf_pkg;

   localparam int SAMPLE_WIDTH      = 16;
   localparam int CHANNEL_WIDTH     = 16;
   localparam int THRESHOLD_WIDTH   = 12;
   localparam int FACTOR_WIDTH      = 5;
   localparam int DIVISOR_WIDTH     = 12;
   localparam int START_WIDTH       = 17;
   localparam int CHARGE_WIDTH      = 32;
   localparam int TOT_WIDTH         = 18;
   localparam int LIMIT_WIDTH       = 16;
   localparam int MAX_SAMPLES       = 8192;
   localparam int INDEX_WIDTH       = $clog2(MAX_SAMPLES);
   localparam int MAX_DOWNSAMPLE    = 16;
   localparam int THRESH_SCALE      = 10;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int DIV_COUNT_WIDTH   = $clog2(CHARGE_WIDTH);
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 12;

   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = THRESHOLD_WIDTH'(10);
   localparam logic [FACTOR_WIDTH-1:0]    FACTOR_RESET    = FACTOR_WIDTH'(1);
   localparam logic [DIVISOR_WIDTH-1:0]   DIVISOR_RESET   = DIVISOR_WIDTH'(99);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THRESHOLD         = 2'd0,
      CSR_DOWNSAMPLE_FACTOR = 2'd1,
      CSR_CHARGE_DIVISOR    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [THRESHOLD_WIDTH-1:0] threshold;
      logic [FACTOR_WIDTH-1:0]    downsample_factor;
      logic [DIVISOR_WIDTH-1:0]   charge_divisor;
   } cfg_type;

   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] hit_channel;
      logic [START_WIDTH-1:0]   start_time;
      logic [CHARGE_WIDTH-1:0]  charge_sum;
      logic [TOT_WIDTH-1:0]     tot_count;
   } hit_entry_type;

   typedef struct packed {
      logic          valid;
      hit_entry_type entry;
   } hit_push_type;

   typedef struct packed {
      logic          not_empty;
      logic          full;
      hit_entry_type head;
   } queue_status_type;

endpackage

>>> rtl/core/thf_if.sv
interface thf_req_if import thf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic [CHANNEL_WIDTH-1:0]  channel;
   logic                      last_sample;

   modport source (output valid, output sample, output channel, output last_sample,
                   input ready);
   modport sink   (input valid, input sample, input channel, input last_sample,
                   output ready);
endinterface

interface thf_rsp_if import thf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CHANNEL_WIDTH-1:0] hit_channel;
   logic [START_WIDTH-1:0]   start_time;
   logic [CHARGE_WIDTH-1:0]  charge;
   logic [TOT_WIDTH-1:0]     time_over_threshold;

   modport source (output valid, output hit_channel, output start_time, output charge,
                   output time_over_threshold, input ready);
   modport sink   (input valid, input hit_channel, input start_time, input charge,
                   input time_over_threshold, output ready);
endinterface

>>> rtl/core/thf_front.sv
module thf_front import thf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   thf_req_if.sink          req_chan,
   input  queue_status_type queue_status,
   output hit_push_type     hit_push
);

   logic                   in_hit_ff, in_hit_in;
   logic [INDEX_WIDTH-1:0] sample_index_ff, sample_index_in;
   logic [START_WIDTH-1:0] hit_start_ff, hit_start_in;
   logic [CHARGE_WIDTH-1:0] charge_sum_ff, charge_sum_in;
   logic [TOT_WIDTH-1:0]   tot_count_ff, tot_count_in;

   logic                        accept;
   logic [FACTOR_WIDTH-1:0]     factor;
   logic [LIMIT_WIDTH-1:0]      limit;
   logic                        over;
   logic [FACTOR_WIDTH+SAMPLE_WIDTH-2:0] scaled_sample;
   logic [CHARGE_WIDTH:0]       charge_next;
   logic [TOT_WIDTH:0]          tot_next;
   logic [INDEX_WIDTH+FACTOR_WIDTH-1:0] start_product;

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // clamp factor into 1..max
   always_comb begin
      if (cfg.downsample_factor == '0) begin
         factor = FACTOR_WIDTH'(1);
      end else if (cfg.downsample_factor > FACTOR_WIDTH'(MAX_DOWNSAMPLE)) begin
         factor = FACTOR_WIDTH'(MAX_DOWNSAMPLE);
      end else begin
         factor = cfg.downsample_factor;
      end
   end

   assign limit = LIMIT_WIDTH'(cfg.threshold * THRESH_SCALE);
   assign over  = $signed({req_chan.sample[SAMPLE_WIDTH-1], req_chan.sample})
                  > $signed({1'b0, limit});

   // sample is positive whenever it is used here, so the sign bit drops
   assign scaled_sample = (FACTOR_WIDTH+SAMPLE_WIDTH-1)'(req_chan.sample[SAMPLE_WIDTH-2:0])
                          * (FACTOR_WIDTH+SAMPLE_WIDTH-1)'(factor);
   assign charge_next   = {1'b0, charge_sum_ff} + (CHARGE_WIDTH+1)'(scaled_sample);
   assign tot_next      = {1'b0, tot_count_ff} + (TOT_WIDTH+1)'(factor);
   assign start_product = (INDEX_WIDTH+FACTOR_WIDTH)'(sample_index_ff)
                          * (INDEX_WIDTH+FACTOR_WIDTH)'(factor);

   always_comb begin
      in_hit_in       = in_hit_ff;
      sample_index_in = sample_index_ff;
      hit_start_in    = hit_start_ff;
      charge_sum_in   = charge_sum_ff;
      tot_count_in    = tot_count_ff;
      hit_push.valid             = 1'b0;
      hit_push.entry.hit_channel = req_chan.channel;
      hit_push.entry.start_time  = hit_start_ff;
      hit_push.entry.charge_sum  = charge_sum_ff;
      hit_push.entry.tot_count   = tot_count_ff;
      if (accept) begin
         if (req_chan.last_sample) begin
            in_hit_in       = 1'b0;
            sample_index_in = '0;
            hit_start_in    = '0;
            charge_sum_in   = '0;
            tot_count_in    = '0;
         end else begin
            if (over && !in_hit_ff) begin
               hit_start_in  = start_product[START_WIDTH-1:0];
               charge_sum_in = CHARGE_WIDTH'(req_chan.sample[SAMPLE_WIDTH-2:0]);
               tot_count_in  = TOT_WIDTH'(factor);
               in_hit_in     = 1'b1;
            end else if (over && in_hit_ff) begin
               charge_sum_in = charge_next[CHARGE_WIDTH] ? '1
                                                         : charge_next[CHARGE_WIDTH-1:0];
               tot_count_in  = tot_next[TOT_WIDTH] ? '1 : tot_next[TOT_WIDTH-1:0];
            end else if (!over && in_hit_ff) begin
               hit_push.valid = 1'b1;
               in_hit_in      = 1'b0;
               hit_start_in   = '0;
               charge_sum_in  = '0;
               tot_count_in   = '0;
            end
            if (sample_index_ff == INDEX_WIDTH'(MAX_SAMPLES - 1)) begin
               sample_index_in = '0;
            end else begin
               sample_index_in = sample_index_ff + INDEX_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hit_ff       <= 1'b0;
         sample_index_ff <= '0;
         hit_start_ff    <= '0;
         charge_sum_ff   <= '0;
         tot_count_ff    <= '0;
      end else begin
         in_hit_ff       <= in_hit_in;
         sample_index_ff <= sample_index_in;
         hit_start_ff    <= hit_start_in;
         charge_sum_ff   <= charge_sum_in;
         tot_count_ff    <= tot_count_in;
      end
   end

endmodule

>>> rtl/core/thf_queue.sv
module thf_queue import thf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  hit_push_type     hit_push,
   input  logic             pop,
   output queue_status_type queue_status
);

   hit_entry_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (hit_push.valid) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
      end
      if (hit_push.valid && !pop) begin
         count_in = count_ff + (QUEUE_PTR_WIDTH+1)'(1);
      end else if (!hit_push.valid && pop) begin
         count_in = count_ff - (QUEUE_PTR_WIDTH+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (hit_push.valid) begin
         entries_ff[wr_ptr_ff] <= hit_push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign queue_status.not_empty = (count_ff != '0);
   assign queue_status.full      = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign queue_status.head      = entries_ff[rd_ptr_ff];

endmodule

>>> rtl/core/thf_back.sv
module thf_back import thf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type queue_status,
   output logic             pop,
   thf_rsp_if.source        rsp_chan
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      DONE
   } state_type;

   state_type                   state_ff;
   logic [DIV_COUNT_WIDTH-1:0]  count_ff;
   logic [CHARGE_WIDTH-1:0]     quot_ff;
   logic [DIVISOR_WIDTH-1:0]    rem_ff;
   logic [CHANNEL_WIDTH-1:0]    channel_ff;
   logic [START_WIDTH-1:0]      start_ff;
   logic [TOT_WIDTH-1:0]        tot_ff;
   logic                        valid_ff;

   logic [DIVISOR_WIDTH:0]      rem_shift;
   logic [DIVISOR_WIDTH:0]      rem_diff;
   logic                        fits;
   logic [DIVISOR_WIDTH-1:0]    rem_in;
   logic [CHARGE_WIDTH-1:0]     quot_in;

   // one restoring step per cycle; a zero divisor yields all ones
   assign rem_shift = {rem_ff, quot_ff[CHARGE_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, cfg.charge_divisor};
   assign fits      = (rem_shift >= {1'b0, cfg.charge_divisor});
   assign rem_in    = fits ? rem_diff[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
   assign quot_in   = {quot_ff[CHARGE_WIDTH-2:0], fits};

   assign pop = (state_ff == IDLE) && queue_status.not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (queue_status.not_empty) begin
                  quot_ff    <= queue_status.head.charge_sum;
                  rem_ff     <= '0;
                  channel_ff <= queue_status.head.hit_channel;
                  start_ff   <= queue_status.head.start_time;
                  tot_ff     <= queue_status.head.tot_count;
                  count_ff   <= '0;
                  state_ff   <= DIVIDE;
               end
            end
            DIVIDE: begin
               quot_ff  <= quot_in;
               rem_ff   <= rem_in;
               count_ff <= count_ff + DIV_COUNT_WIDTH'(1);
               if (count_ff == DIV_COUNT_WIDTH'(CHARGE_WIDTH - 1)) begin
                  valid_ff <= 1'b1;
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (rsp_chan.ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= IDLE;
               end
            end
            default: begin
               valid_ff <= 1'b0;
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.hit_channel         = channel_ff;
   assign rsp_chan.start_time          = start_ff;
   assign rsp_chan.charge              = quot_ff;
   assign rsp_chan.time_over_threshold = tot_ff;

endmodule

>>> rtl/core/threshold_hit_finder.sv
// a hit-ending item pushes its hit into the queue; the divider loads it when idle, then presents the quotient
// throughput: one input item per cycle while the hit queue has room
// each finished hit holds the divider through a load, a 32-step restoring divide and the
// hand-off; a four-deep queue absorbs hits that end close together
// reset: synchronous, active high; registers go to defaults, hit state and queue clear
module threshold_hit_finder import thf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   thf_req_if.sink                    req_chan,
   thf_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type          cfg_ff;
   hit_push_type     hit_push;
   queue_status_type queue_status;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold         <= THRESHOLD_RESET;
         cfg_ff.downsample_factor <= FACTOR_RESET;
         cfg_ff.charge_divisor    <= DIVISOR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: begin
               cfg_ff.threshold <= csr_write_data[THRESHOLD_WIDTH-1:0];
            end
            CSR_DOWNSAMPLE_FACTOR: begin
               cfg_ff.downsample_factor <= csr_write_data[FACTOR_WIDTH-1:0];
            end
            CSR_CHARGE_DIVISOR: begin
               cfg_ff.charge_divisor <= csr_write_data[DIVISOR_WIDTH-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   thf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .hit_push     (hit_push)
   );

   thf_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .hit_push     (hit_push),
      .pop          (pop),
      .queue_status (queue_status)
   );

   thf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule
